// ===== rtl/tapt_pkg.sv =====
// ----------------------------------------------------------------------------
// tapt_pkg
// Shared types and constants of the two-axis incremental PI tracker.
// ----------------------------------------------------------------------------
package tapt_pkg;

  localparam int BallXW = 9;
  localparam int BallYW = 8;
  localparam int GoalW  = 12;
  localparam int GainW  = 16;
  localparam int ErrW   = 10;
  localparam int ProdW  = GainW + ErrW + 1;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam int GoalCenter = 2048;
  localparam int XMax = 1000;
  localparam int XMin = -1000;
  localparam int YMax = 200;
  localparam int YMin = -900;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REF_X       = 3'd0,
    CFG_REF_Y       = 3'd1,
    CFG_GAIN_CUR_X  = 3'd2,
    CFG_GAIN_PREV_X = 3'd3,
    CFG_GAIN_CUR_Y  = 3'd4,
    CFG_GAIN_PREV_Y = 3'd5
  } cfg_idx_e;

  typedef logic signed [ErrW-1:0]  err_t;
  typedef logic signed [ProdW-1:0] prod_t;

endpackage

// ===== rtl/tapt_in_if.sv =====
// ----------------------------------------------------------------------------
// tapt_in_if
// Input channel: one item is a sampling tick or a disable request.
// ----------------------------------------------------------------------------
interface tapt_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [tapt_pkg::BallXW-1:0] ball_x;
  logic [tapt_pkg::BallYW-1:0] ball_y;

  modport source (output valid, output func, output ball_x, output ball_y, input ready);
  modport sink   (input valid, input func, input ball_x, input ball_y, output ready);
endinterface

// ===== rtl/tapt_out_if.sv =====
// ----------------------------------------------------------------------------
// tapt_out_if
// Output channel: one item carries the pan and tilt servo goals.
// ----------------------------------------------------------------------------
interface tapt_out_if;
  logic                       valid;
  logic                       ready;
  logic [tapt_pkg::GoalW-1:0] pan_goal;
  logic [tapt_pkg::GoalW-1:0] tilt_goal;

  modport source (output valid, output pan_goal, output tilt_goal, input ready);
  modport sink   (input valid, input pan_goal, input tilt_goal, output ready);
endinterface

// ===== rtl/two_axis_incremental_pi_tracker.sv =====
// ----------------------------------------------------------------------------
// two_axis_incremental_pi_tracker
// Pan/tilt tracker built from two velocity-form PI loops with clamped commands.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle while the output is not stalled. The
// servo goals of a sampling tick pass from the input register, which holds the
// errors, to the result register: the gain products, the clamped command update
// and the goal subtraction run in one pass between them. A disable item clears
// both commands and produces no output item. One item is held in the input
// register while the output item waits to be taken.
module two_axis_incremental_pi_tracker #(
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tapt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tapt_pkg::CfgDataW-1:0] cfg_data_i,
  tapt_in_if.sink                       in_i,
  tapt_out_if.source                    out_o
);

  localparam int CmdW  = 11 + FRAC_BITS;
  localparam int SumW  = ((CmdW > tapt_pkg::ProdW) ? CmdW : tapt_pkg::ProdW) + 2;
  localparam int DiffW = 13 + FRAC_BITS;
  localparam int Unit  = 2 ** FRAC_BITS;

  localparam logic signed [SumW-1:0] XHi = SumW'(tapt_pkg::XMax * Unit);
  localparam logic signed [SumW-1:0] XLo = SumW'(tapt_pkg::XMin * Unit);
  localparam logic signed [SumW-1:0] YHi = SumW'(tapt_pkg::YMax * Unit);
  localparam logic signed [SumW-1:0] YLo = SumW'(tapt_pkg::YMin * Unit);
  localparam logic signed [DiffW-1:0] Center = DiffW'(tapt_pkg::GoalCenter * Unit);

  logic [tapt_pkg::BallXW-1:0] ref_x_q;
  logic [tapt_pkg::BallYW-1:0] ref_y_q;
  logic [tapt_pkg::GainW-1:0]  gain_cur_x_q, gain_prev_x_q, gain_cur_y_q, gain_prev_y_q;

  tapt_pkg::err_t last_err_x_q, last_err_y_q;
  tapt_pkg::err_t err_x_d, err_y_d;

  logic           s1_v_q, s1_func_q;
  tapt_pkg::err_t s1_err_x_q, s1_perr_x_q, s1_err_y_q, s1_perr_y_q;

  tapt_pkg::prod_t px_d, qx_d, py_d, qy_d;

  logic signed [CmdW-1:0] cmd_x_q, cmd_y_q, cmd_x_d, cmd_y_d;
  logic signed [SumW-1:0] sum_x, sum_y;
  logic signed [DiffW-1:0] diff_x, diff_y;

  logic                       out_v_q;
  logic [tapt_pkg::GoalW-1:0] pan_q, tilt_q;

  logic out_free, s1_go, s1_free, in_acc;

  assign out_free = !out_v_q || out_o.ready;
  assign s1_go    = s1_v_q && (!s1_func_q || out_free);
  assign s1_free  = !s1_v_q || s1_go;
  assign in_acc   = in_i.valid && s1_free;

  assign in_i.ready      = s1_free;
  assign out_o.valid     = out_v_q;
  assign out_o.pan_goal  = pan_q;
  assign out_o.tilt_goal = tilt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q       <= tapt_pkg::BallXW'(160);
      ref_y_q       <= tapt_pkg::BallYW'(120);
      gain_cur_x_q  <= tapt_pkg::GainW'(8615);
      gain_prev_x_q <= tapt_pkg::GainW'(82);
      gain_cur_y_q  <= tapt_pkg::GainW'(8650);
      gain_prev_y_q <= tapt_pkg::GainW'(109);
    end else if (cfg_we_i) begin
      unique case (tapt_pkg::cfg_idx_e'(cfg_idx_i))
        tapt_pkg::CFG_REF_X:       ref_x_q       <= cfg_data_i[tapt_pkg::BallXW-1:0];
        tapt_pkg::CFG_REF_Y:       ref_y_q       <= cfg_data_i[tapt_pkg::BallYW-1:0];
        tapt_pkg::CFG_GAIN_CUR_X:  gain_cur_x_q  <= cfg_data_i;
        tapt_pkg::CFG_GAIN_PREV_X: gain_prev_x_q <= cfg_data_i;
        tapt_pkg::CFG_GAIN_CUR_Y:  gain_cur_y_q  <= cfg_data_i;
        tapt_pkg::CFG_GAIN_PREV_Y: gain_prev_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign err_x_d = $signed({1'b0, in_i.ball_x}) - $signed({1'b0, ref_x_q});
  assign err_y_d = $signed({2'b00, in_i.ball_y}) - $signed({2'b00, ref_y_q});

  // The previous error of a tick is the error of the last tick before it,
  // whatever disable items came in between.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q       <= 1'b0;
      last_err_x_q <= '0;
      last_err_y_q <= '0;
    end else begin
      if (s1_free) begin
        s1_v_q <= in_i.valid;
      end
      if (in_acc && in_i.func) begin
        last_err_x_q <= err_x_d;
        last_err_y_q <= err_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q   <= in_i.func;
      s1_err_x_q  <= err_x_d;
      s1_err_y_q  <= err_y_d;
      s1_perr_x_q <= last_err_x_q;
      s1_perr_y_q <= last_err_y_q;
    end
  end

  assign px_d = $signed({1'b0, gain_cur_x_q})  * s1_err_x_q;
  assign qx_d = $signed({1'b0, gain_prev_x_q}) * s1_perr_x_q;
  assign py_d = $signed({1'b0, gain_cur_y_q})  * s1_err_y_q;
  assign qy_d = $signed({1'b0, gain_prev_y_q}) * s1_perr_y_q;

  always_comb begin
    sum_x = SumW'(cmd_x_q) + SumW'(px_d) - SumW'(qx_d);
    sum_y = SumW'(cmd_y_q) + SumW'(py_d) - SumW'(qy_d);
    priority if (sum_x > XHi) begin
      cmd_x_d = CmdW'(XHi);
    end else if (sum_x < XLo) begin
      cmd_x_d = CmdW'(XLo);
    end else begin
      cmd_x_d = CmdW'(sum_x);
    end
    priority if (sum_y > YHi) begin
      cmd_y_d = CmdW'(YHi);
    end else if (sum_y < YLo) begin
      cmd_y_d = CmdW'(YLo);
    end else begin
      cmd_y_d = CmdW'(sum_y);
    end
    diff_x = Center - DiffW'(cmd_x_d);
    diff_y = Center - DiffW'(cmd_y_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_x_q <= '0;
      cmd_y_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_go) begin
        if (s1_func_q) begin
          cmd_x_q <= cmd_x_d;
          cmd_y_q <= cmd_y_d;
        end else begin
          cmd_x_q <= '0;
          cmd_y_q <= '0;
        end
      end
      if (s1_go && s1_func_q) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_func_q) begin
      pan_q  <= diff_x[FRAC_BITS +: tapt_pkg::GoalW];
      tilt_q <= diff_y[FRAC_BITS +: tapt_pkg::GoalW];
    end
  end

endmodule

// ===== verif/two_axis_incremental_pi_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// two_axis_incremental_pi_tracker_tb
// Self-checking testbench for the two-axis velocity-form PI tracker.
// A table of directed items comes first: centered, extreme and disabled
// positions under the reset gains. It is followed by randomized phases, each
// under its own reference and gain setting. Most random items walk the ball
// near the reference. The rest are disable items and positions anywhere in
// the field width. A behavioral tracker predicts the pan and tilt goals of
// every tick. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module two_axis_incremental_pi_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits    = 8;
  localparam longint OneUnit = longint'(1) << FracBits;
  localparam int PhaseCount  = 7;
  localparam int PhaseItems  = 250;
  localparam int DrainCycles = 16;
  localparam int CycleLimit  = 400000;

  localparam logic [tapt_pkg::CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [tapt_pkg::CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  typedef logic signed [FracBits+10:0] cmd_t;

  typedef struct packed {
    logic [tapt_pkg::GoalW-1:0] pan;
    logic [tapt_pkg::GoalW-1:0] tilt;
  } goals_t;

  typedef struct packed {
    logic                        on;
    logic [tapt_pkg::BallXW-1:0] bx;
    logic [tapt_pkg::BallYW-1:0] by;
    logic                        typed;
    goals_t                      want;
  } probe_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [tapt_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [tapt_pkg::CfgDataW-1:0] cfg_data_i;

  tapt_in_if  in_ch ();
  tapt_out_if out_ch ();

  two_axis_incremental_pi_tracker #(
    .FRAC_BITS(FracBits)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i(in_ch),
    .out_o(out_ch)
  );

  logic [tapt_pkg::BallXW-1:0] aim_x = 9'd160;
  logic [tapt_pkg::BallYW-1:0] aim_y = 8'd120;
  logic [tapt_pkg::GainW-1:0]  kc_x  = 16'd8615;
  logic [tapt_pkg::GainW-1:0]  kp_x  = 16'd82;
  logic [tapt_pkg::GainW-1:0]  kc_y  = 16'd8650;
  logic [tapt_pkg::GainW-1:0]  kp_y  = 16'd109;
  tapt_pkg::err_t              err_x_now = '0;
  tapt_pkg::err_t              err_x_old = '0;
  tapt_pkg::err_t              err_y_now = '0;
  tapt_pkg::err_t              err_y_old = '0;
  cmd_t                        drive_x   = '0;
  cmd_t                        drive_y   = '0;

  goals_t awaited_goals[$];
  probe_t probes[14];
  int     mismatches     = 0;
  int     cycle_count    = 0;
  int     feed_gap_pct   = 0;
  int     sink_stall_pct = 0;
  int     sink_hold      = 0;

  always #10 clk_i = ~clk_i;

  function automatic void store_reg(input logic [tapt_pkg::CfgIdxW-1:0] idx,
                                    input logic [tapt_pkg::CfgDataW-1:0] val);
    case (idx)
      tapt_pkg::CFG_REF_X:       aim_x = val[tapt_pkg::BallXW-1:0];
      tapt_pkg::CFG_REF_Y:       aim_y = val[tapt_pkg::BallYW-1:0];
      tapt_pkg::CFG_GAIN_CUR_X:  kc_x  = val[tapt_pkg::GainW-1:0];
      tapt_pkg::CFG_GAIN_PREV_X: kp_x  = val[tapt_pkg::GainW-1:0];
      tapt_pkg::CFG_GAIN_CUR_Y:  kc_y  = val[tapt_pkg::GainW-1:0];
      tapt_pkg::CFG_GAIN_PREV_Y: kp_y  = val[tapt_pkg::GainW-1:0];
      default: ;
    endcase
  endfunction

  function automatic cmd_t pi_update(input cmd_t c, input tapt_pkg::err_t e,
                                     input tapt_pkg::err_t pe,
                                     input logic [tapt_pkg::GainW-1:0] gc,
                                     input logic [tapt_pkg::GainW-1:0] gp,
                                     input int lo, input int hi);
    longint acc;
    acc = longint'(c) + longint'(gc) * longint'(e) - longint'(gp) * longint'(pe);
    if (acc < longint'(lo) * OneUnit) acc = longint'(lo) * OneUnit;
    if (acc > longint'(hi) * OneUnit) acc = longint'(hi) * OneUnit;
    return cmd_t'(acc);
  endfunction

  function automatic logic [tapt_pkg::GoalW-1:0] goal_from(input cmd_t c);
    longint d;
    d = longint'(tapt_pkg::GoalCenter) * OneUnit - longint'(c);
    return tapt_pkg::GoalW'(d >>> FracBits);
  endfunction

  function automatic bit track_step(input logic on,
                                    input logic [tapt_pkg::BallXW-1:0] bx,
                                    input logic [tapt_pkg::BallYW-1:0] by,
                                    output goals_t g);
    g = '0;
    if (!on) begin
      err_x_old = '0;
      err_y_old = '0;
      drive_x   = '0;
      drive_y   = '0;
      return 1'b0;
    end
    err_x_old = err_x_now;
    err_x_now = tapt_pkg::err_t'(int'(bx) - int'(aim_x));
    drive_x   = pi_update(drive_x, err_x_now, err_x_old, kc_x, kp_x,
                          tapt_pkg::XMin, tapt_pkg::XMax);
    err_y_old = err_y_now;
    err_y_now = tapt_pkg::err_t'(int'(by) - int'(aim_y));
    drive_y   = pi_update(drive_y, err_y_now, err_y_old, kc_y, kp_y,
                          tapt_pkg::YMin, tapt_pkg::YMax);
    g.pan  = goal_from(drive_x);
    g.tilt = goal_from(drive_y);
    return 1'b1;
  endfunction

  function automatic logic [tapt_pkg::CfgDataW-1:0] rand_gain();
    if ($urandom_range(0, 3) == 0) return tapt_pkg::CfgDataW'($urandom);
    return tapt_pkg::CfgDataW'($urandom_range(0, 3000));
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic write_reg(input logic [tapt_pkg::CfgIdxW-1:0] idx,
                           input logic [tapt_pkg::CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    store_reg(idx, val);
  endtask

  task automatic load_setting(input logic [tapt_pkg::CfgDataW-1:0] rx,
                              input logic [tapt_pkg::CfgDataW-1:0] ry,
                              input logic [tapt_pkg::CfgDataW-1:0] gcx,
                              input logic [tapt_pkg::CfgDataW-1:0] gpx,
                              input logic [tapt_pkg::CfgDataW-1:0] gcy,
                              input logic [tapt_pkg::CfgDataW-1:0] gpy);
    write_reg(tapt_pkg::CFG_REF_X, rx);
    write_reg(tapt_pkg::CFG_REF_Y, ry);
    write_reg(tapt_pkg::CFG_GAIN_CUR_X, gcx);
    write_reg(tapt_pkg::CFG_GAIN_PREV_X, gpx);
    write_reg(tapt_pkg::CFG_GAIN_CUR_Y, gcy);
    write_reg(tapt_pkg::CFG_GAIN_PREV_Y, gpy);
    write_reg(CfgIdxSpareLo, tapt_pkg::CfgDataW'($urandom));
    write_reg(CfgIdxSpareHi, tapt_pkg::CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (awaited_goals.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic feed_item(input logic on, input logic [tapt_pkg::BallXW-1:0] bx,
                           input logic [tapt_pkg::BallYW-1:0] by, input bit typed,
                           input goals_t typed_goals);
    goals_t g;
    bit     emits;
    if ($urandom_range(0, 99) < feed_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.func   <= on;
    in_ch.ball_x <= bx;
    in_ch.ball_y <= by;
    do @(negedge clk_i); while (!in_ch.ready);
    emits = track_step(on, bx, by, g);
    if (emits) awaited_goals.push_back(typed ? typed_goals : g);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (sink_hold == 0 && $urandom_range(0, 99) < sink_stall_pct) begin
      sink_hold = $urandom_range(1, 10);
    end
    if (sink_hold > 0) begin
      sink_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    goals_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (awaited_goals.size() == 0) begin
        note_mismatch($sformatf("unexpected item pan=%0d tilt=%0d",
                                out_ch.pan_goal, out_ch.tilt_goal));
      end else begin
        want = awaited_goals.pop_front();
        if (out_ch.pan_goal !== want.pan) begin
          note_mismatch($sformatf("pan_goal %0d, expected %0d", out_ch.pan_goal, want.pan));
        end
        if (out_ch.tilt_goal !== want.tilt) begin
          note_mismatch($sformatf("tilt_goal %0d, expected %0d", out_ch.tilt_goal, want.tilt));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    int          walk_x;
    int          walk_y;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_ch.valid  = 1'b0;
    in_ch.func   = 1'b0;
    in_ch.ball_x = '0;
    in_ch.ball_y = '0;
    out_ch.ready = 1'b0;

    probes = '{
      '{1'b1, 9'd160, 8'd120, 1'b1, '{12'd2048, 12'd2048}},
      '{1'b1, 9'd511, 8'd255, 1'b1, '{12'd1048, 12'd1848}},
      '{1'b1, 9'd0,   8'd0,   1'b1, '{12'd3048, 12'd2948}},
      '{1'b0, 9'd511, 8'd255, 1'b0, '{12'd0,    12'd0}},
      '{1'b1, 9'd160, 8'd120, 1'b0, '{12'd0,    12'd0}},
      '{1'b1, 9'd161, 8'd121, 1'b0, '{12'd0,    12'd0}},
      '{1'b1, 9'd170, 8'd110, 1'b0, '{12'd0,    12'd0}},
      '{1'b0, 9'd0,   8'd0,   1'b0, '{12'd0,    12'd0}},
      '{1'b0, 9'd300, 8'd200, 1'b0, '{12'd0,    12'd0}},
      '{1'b1, 9'd319, 8'd239, 1'b0, '{12'd0,    12'd0}},
      '{1'b1, 9'h155, 8'haa,  1'b0, '{12'd0,    12'd0}},
      '{1'b1, 9'h0aa, 8'h55,  1'b0, '{12'd0,    12'd0}},
      '{1'b1, 9'd159, 8'd119, 1'b0, '{12'd0,    12'd0}},
      '{1'b1, 9'd160, 8'd120, 1'b0, '{12'd0,    12'd0}}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    feed_gap_pct   = 25;
    sink_stall_pct = 25;
    foreach (probes[i]) begin
      feed_item(probes[i].on, probes[i].bx, probes[i].by, probes[i].typed, probes[i].want);
    end
    in_ch.valid <= 1'b0;

    for (int k = 0; k < PhaseCount; k++) begin
      wait_idle();
      case (k)
        0: load_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        1: load_setting(16'd511, 16'd255, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        2: load_setting(16'd160, 16'd120, 16'd8615, 16'd82, 16'd8650, 16'd109);
        default: begin
          load_setting(
            tapt_pkg::CfgDataW'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 511 : 319)),
            tapt_pkg::CfgDataW'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 255 : 239)),
            rand_gain(), rand_gain(), rand_gain(), rand_gain());
        end
      endcase
      feed_gap_pct   = (k == PhaseCount - 1) ? 0 : (k % 3) * 20;
      sink_stall_pct = (k == PhaseCount - 1) ? 0 : ((k + 1) % 3) * 20;
      walk_x = int'(aim_x);
      walk_y = int'(aim_y);
      @(posedge clk_i);
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          feed_item(1'b0, tapt_pkg::BallXW'($urandom), tapt_pkg::BallYW'($urandom), 1'b0, '0);
        end else if (pick < 22) begin
          feed_item(1'b1, tapt_pkg::BallXW'($urandom), tapt_pkg::BallYW'($urandom), 1'b0, '0);
        end else begin
          walk_x += int'($urandom_range(0, 12)) - 6;
          walk_y += int'($urandom_range(0, 12)) - 6;
          walk_x = (walk_x < 0) ? 0 : (walk_x > 511) ? 511 : walk_x;
          walk_y = (walk_y < 0) ? 0 : (walk_y > 255) ? 255 : walk_y;
          feed_item(1'b1, tapt_pkg::BallXW'(walk_x), tapt_pkg::BallYW'(walk_y), 1'b0, '0);
        end
      end
      in_ch.valid <= 1'b0;
    end

    wait_idle();
    if (awaited_goals.size() != 0) begin
      note_mismatch($sformatf("%0d expected items never arrived", awaited_goals.size()));
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tapt_pkg.sv
rtl/tapt_in_if.sv
rtl/tapt_out_if.sv
rtl/two_axis_incremental_pi_tracker.sv
verif/two_axis_incremental_pi_tracker_tb.sv
